FILE: rtl/core/imu_sensor_error_compensation_macros.svh
// ----------------------------------------------------------------------------
// imu sensor error compensation assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef IMU_SENSOR_ERROR_COMPENSATION_MACROS_SVH
`define IMU_SENSOR_ERROR_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS

`define IMUC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imuc assertion failed");

`define IMUC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imuc assertion failed");

`else

`define IMUC_ASSERT_SAME(label, clk, rst, ante, cons)

`define IMUC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/imuc_pkg.sv
// ----------------------------------------------------------------------------
// imuc_pkg
// shared constants for the imu sensor error compensation block
// ----------------------------------------------------------------------------
package imuc_pkg;

   localparam int AXES            = 3;
   localparam int COEF_FIELD_BITS = 16;
   localparam int CSR_W           = 48;
   localparam int CSR_INDEX_W     = 3;
   localparam int CMD_W           = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_BIAS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_SCALE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_MISALIGN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_SCALE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_MISALIGN = 3'd4;

   localparam logic [CMD_W-1:0] CMD_COMPENSATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_BIAS   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD_BIAS  = 2'd2;

endpackage

FILE: rtl/core/imuc_matrix.sv
// ----------------------------------------------------------------------------
// imuc_matrix
// symmetric 3x3 scale and misalignment multiply with registered products,
// then round half up, floor shift and saturate to the sample range
// ----------------------------------------------------------------------------
module imuc_matrix #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                load,
   input  logic signed [SAMPLE_WIDTH:0]        diff [imuc_pkg::AXES],
   input  logic [imuc_pkg::CSR_W-1:0]          scale,
   input  logic [imuc_pkg::CSR_W-1:0]          misalign,
   output logic signed [SAMPLE_WIDTH-1:0]      result [imuc_pkg::AXES],
   output logic                                saturated
);
   import imuc_pkg::*;

   localparam int PROD_W = SAMPLE_WIDTH + COEF_FIELD_BITS + 1;
   localparam int ACC_W  = SAMPLE_WIDTH + COEF_FIELD_BITS + 4;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAMPLE_MAX = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - 1;
   localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - 1;

   logic signed [PROD_W-1:0] prod_ff [AXES][AXES];
   logic signed [PROD_W-1:0] prod_in [AXES][AXES];

   for (genvar i = 0; i < AXES; i++) begin : g_row
      for (genvar j = 0; j < AXES; j++) begin : g_col
         logic signed [COEF_FIELD_BITS-1:0] coef;
         if (i == j) begin : g_diag
            assign coef = scale[i*COEF_FIELD_BITS +: COEF_FIELD_BITS];
         end else begin : g_off
            assign coef = misalign[(i+j-1)*COEF_FIELD_BITS +: COEF_FIELD_BITS];
         end
         assign prod_in[i][j] = PROD_W'(coef * diff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] shifted;
      saturated = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         acc = ACC_W'(prod_ff[i][0]) + ACC_W'(prod_ff[i][1]) + ACC_W'(prod_ff[i][2])
               + ROUND_HALF;
         shifted = acc >>> COEF_FRAC_BITS;
         if (shifted > SAMPLE_MAX) begin
            result[i] = SAMPLE_WIDTH'(SAMPLE_MAX);
            saturated = 1'b1;
         end else if (shifted < SAMPLE_MIN) begin
            result[i] = SAMPLE_WIDTH'(SAMPLE_MIN);
            saturated = 1'b1;
         end else begin
            result[i] = SAMPLE_WIDTH'(shifted);
         end
      end
   end

endmodule

FILE: rtl/core/imu_sensor_error_compensation.sv
// ----------------------------------------------------------------------------
// imu_sensor_error_compensation
// bias removal and scale / misalignment correction of gyro and accel samples
// three-stage pipeline: bias and difference register, product register and
//    response register
// throughput: one request per cycle while rsp_ready does not stall the output
// reset: synchronous; clears pipeline valids, accel biases, gyro biases and
//    misalignments, and sets all scale factors to 1.0
// ----------------------------------------------------------------------------
`include "imu_sensor_error_compensation_macros.svh"

module imu_sensor_error_compensation #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [imuc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [imuc_pkg::CSR_W-1:0]             csr_wdata,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [imuc_pkg::CMD_W-1:0]             req_command,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_gyro_x,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_gyro_y,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_gyro_z,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_accel_z,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_gyro_out_x,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_gyro_out_y,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_gyro_out_z,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_accel_out_x,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_accel_out_y,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_accel_out_z,
   output logic                                   rsp_saturated
);
   import imuc_pkg::*;

   localparam int SW = SAMPLE_WIDTH;

   localparam logic [CSR_W-1:0] SCALE_ONE = CSR_W'((64'd1 << COEF_FRAC_BITS)
      | (64'd1 << (COEF_FRAC_BITS + COEF_FIELD_BITS))
      | (64'd1 << (COEF_FRAC_BITS + 2 * COEF_FIELD_BITS)));

   localparam logic signed [SW-1:0] BIAS_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] BIAS_MIN = {1'b1, {(SW-1){1'b0}}};

   // configuration
   logic [CSR_W-1:0] gyro_bias_ff, gyro_scale_ff, gyro_misalign_ff;
   logic [CSR_W-1:0] accel_scale_ff, accel_misalign_ff;

   // accel bias state
   logic signed [SW-1:0] accel_bias_ff [AXES];
   logic signed [SW-1:0] accel_bias_in [AXES];
   logic                 bias_sat_in;

   // handshake
   logic req_fire, out_take, s2_move, s1_move;

   // stage 1: differences and bias result
   logic                 s1_valid_ff;
   logic                 s1_comp_ff;
   logic signed [SW:0]   s1_gdiff_ff [AXES];
   logic signed [SW:0]   s1_adiff_ff [AXES];
   logic signed [SW-1:0] s1_bias_ff  [AXES];
   logic                 s1_bias_sat_ff;
   logic signed [SW:0]   gdiff_in [AXES];
   logic signed [SW:0]   adiff_in [AXES];

   // stage 2: products live in the matrix units
   logic                 s2_valid_ff;
   logic                 s2_comp_ff;
   logic signed [SW-1:0] s2_bias_ff [AXES];
   logic                 s2_bias_sat_ff;
   logic signed [SW-1:0] gyro_res  [AXES];
   logic signed [SW-1:0] accel_res [AXES];
   logic                 gyro_sat, accel_sat;

   // response register
   logic                 rsp_valid_ff;
   logic signed [SW-1:0] rsp_gyro_ff  [AXES];
   logic signed [SW-1:0] rsp_accel_ff [AXES];
   logic                 rsp_sat_ff;
   logic signed [SW-1:0] rsp_gyro_in  [AXES];
   logic signed [SW-1:0] rsp_accel_in [AXES];
   logic                 rsp_sat_in;

   logic signed [SW-1:0] req_gyro  [AXES];
   logic signed [SW-1:0] req_accel [AXES];
   logic [CSR_W+SW-1:0]  gyro_bias_wide;

   assign req_gyro[0]  = req_gyro_x;
   assign req_gyro[1]  = req_gyro_y;
   assign req_gyro[2]  = req_gyro_z;
   assign req_accel[0] = req_accel_x;
   assign req_accel[1] = req_accel_y;
   assign req_accel[2] = req_accel_z;

   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign s2_move   = !s2_valid_ff || out_take;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_ready = s1_move;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign gyro_bias_wide = {{SW{1'b0}}, gyro_bias_ff};

   always_comb begin
      logic signed [SW:0]   bias_sum;
      logic signed [SW-1:0] gyro_bias;
      bias_sat_in = 1'b0;
      for (int k = 0; k < AXES; k++) begin
         gyro_bias   = gyro_bias_wide[k*COEF_FIELD_BITS +: SW];
         gdiff_in[k] = (SW+1)'(req_gyro[k]) - (SW+1)'(gyro_bias);
         adiff_in[k] = (SW+1)'(req_accel[k]) - (SW+1)'(accel_bias_ff[k]);
         bias_sum    = (SW+1)'(accel_bias_ff[k]) + (SW+1)'(req_accel[k]);
         case (req_command)
            CMD_ADD_BIAS: begin
               if (bias_sum[SW] != bias_sum[SW-1]) begin
                  accel_bias_in[k] = bias_sum[SW] ? BIAS_MIN : BIAS_MAX;
                  bias_sat_in      = 1'b1;
               end else begin
                  accel_bias_in[k] = SW'(bias_sum);
               end
            end
            CMD_LOAD_BIAS: begin
               accel_bias_in[k] = req_accel[k];
            end
            default: begin
               accel_bias_in[k] = accel_bias_ff[k];
            end
         endcase
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_bias_ff      <= '0;
         gyro_scale_ff     <= SCALE_ONE;
         gyro_misalign_ff  <= '0;
         accel_scale_ff    <= SCALE_ONE;
         accel_misalign_ff <= '0;
         for (int k = 0; k < AXES; k++) begin
            accel_bias_ff[k] <= '0;
         end
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GYRO_BIAS:      gyro_bias_ff      <= csr_wdata;
               CSR_GYRO_SCALE:     gyro_scale_ff     <= csr_wdata;
               CSR_GYRO_MISALIGN:  gyro_misalign_ff  <= csr_wdata;
               CSR_ACCEL_SCALE:    accel_scale_ff    <= csr_wdata;
               CSR_ACCEL_MISALIGN: accel_misalign_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_fire) begin
            accel_bias_ff <= accel_bias_in;
         end
         if (s1_move) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_take) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_comp_ff     <= (req_command == CMD_COMPENSATE);
         s1_gdiff_ff    <= gdiff_in;
         s1_adiff_ff    <= adiff_in;
         s1_bias_ff     <= accel_bias_in;
         s1_bias_sat_ff <= bias_sat_in;
      end
      if (s2_move && s1_valid_ff) begin
         s2_comp_ff     <= s1_comp_ff;
         s2_bias_ff     <= s1_bias_ff;
         s2_bias_sat_ff <= s1_bias_sat_ff;
      end
      if (out_take && s2_valid_ff) begin
         rsp_gyro_ff  <= rsp_gyro_in;
         rsp_accel_ff <= rsp_accel_in;
         rsp_sat_ff   <= rsp_sat_in;
      end
   end

   imuc_matrix #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_gyro_matrix (
      .clock     (clock),
      .load      (s2_move && s1_valid_ff),
      .diff      (s1_gdiff_ff),
      .scale     (gyro_scale_ff),
      .misalign  (gyro_misalign_ff),
      .result    (gyro_res),
      .saturated (gyro_sat)
   );

   imuc_matrix #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_accel_matrix (
      .clock     (clock),
      .load      (s2_move && s1_valid_ff),
      .diff      (s1_adiff_ff),
      .scale     (accel_scale_ff),
      .misalign  (accel_misalign_ff),
      .result    (accel_res),
      .saturated (accel_sat)
   );

   always_comb begin
      if (s2_comp_ff) begin
         rsp_gyro_in  = gyro_res;
         rsp_accel_in = accel_res;
         rsp_sat_in   = gyro_sat || accel_sat;
      end else begin
         for (int k = 0; k < AXES; k++) begin
            rsp_gyro_in[k] = '0;
         end
         rsp_accel_in = s2_bias_ff;
         rsp_sat_in   = s2_bias_sat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gyro_out_x  = rsp_gyro_ff[0];
   assign rsp_gyro_out_y  = rsp_gyro_ff[1];
   assign rsp_gyro_out_z  = rsp_gyro_ff[2];
   assign rsp_accel_out_x = rsp_accel_ff[0];
   assign rsp_accel_out_y = rsp_accel_ff[1];
   assign rsp_accel_out_z = rsp_accel_ff[2];
   assign rsp_saturated   = rsp_sat_ff;

   `IMUC_ASSERT_NEXT(a_bias_kept_on_compensate, clock, reset,
      req_fire && req_command == CMD_COMPENSATE,
      $stable(accel_bias_ff[0]) && $stable(accel_bias_ff[1]) && $stable(accel_bias_ff[2]))

   `IMUC_ASSERT_NEXT(a_bias_loaded, clock, reset,
      req_fire && req_command == CMD_LOAD_BIAS,
      accel_bias_ff[0] == $past(req_accel_x) && accel_bias_ff[1] == $past(req_accel_y)
      && accel_bias_ff[2] == $past(req_accel_z))

   `IMUC_ASSERT_NEXT(a_stage1_held_on_stall, clock, reset,
      s1_valid_ff && !s2_move,
      s1_valid_ff)

   `IMUC_ASSERT_SAME(a_ready_when_stage1_empty, clock, reset,
      !s1_valid_ff,
      req_ready)

endmodule
